// ===== sv/cell_deinterleave_address_gen_unit_defines.svh =====
// assertion macros shared by the cell deinterleave address generator
// needs a clock named clock and an active high reset named reset in scope
`ifndef CELL_DEINTERLEAVE_ADDRESS_GEN_UNIT_DEFINES_SVH
`define CELL_DEINTERLEAVE_ADDRESS_GEN_UNIT_DEFINES_SVH

// condition and consequence in the same cycle
`define CDAG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define CDAG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cdag_pkg.sv =====
// shared types, constants and functions of the cell deinterleave address generator
// no dependencies
package cdag_pkg;

   localparam int MAX_CELLS_DEF  = 32768;
   localparam int MAX_BLOCKS_DEF = 1023;

   localparam logic [15:0] CELLS_RESET  = 16'd32400;
   localparam logic [15:0] CELLS_FLOOR  = 16'd1025;
   localparam logic [9:0]  BLOCKS_RESET = 10'd1;
   localparam logic [9:0]  BLOCKS_FLOOR = 10'd1;

   localparam logic [3:0] DEG_11 = 4'd11;
   localparam logic [3:0] DEG_12 = 4'd12;
   localparam logic [3:0] DEG_13 = 4'd13;
   localparam logic [3:0] DEG_14 = 4'd14;
   localparam logic [3:0] DEG_15 = 4'd15;

   // configuration register indexes
   localparam logic CSR_CELLS  = 1'b0;
   localparam logic CSR_BLOCKS = 1'b1;

   typedef struct packed {
      logic restart;
      logic shift_adv;
      logic pn_adv;
      logic reduce;
      logic emit;
   } cdag_cmd_type;

   typedef struct packed {
      logic need_shift;
      logic shift_ok;
      logic pn_ok;
      logic target_ok;
   } cdag_stat_type;

   // pn degree: log2 of the smallest power of two at or above the cell count, 11 to 15
   function automatic logic [3:0] degree_of(input logic [15:0] cells);
      logic [3:0] d;
      if (cells <= 16'd2048) begin
         d = DEG_11;
      end else if (cells <= 16'd4096) begin
         d = DEG_12;
      end else if (cells <= 16'd8192) begin
         d = DEG_13;
      end else if (cells <= 16'd16384) begin
         d = DEG_14;
      end else begin
         d = DEG_15;
      end
      return d;
   endfunction

   // one lfsr step over the bits below the toggled top bit
   function automatic logic [13:0] lfsr_next(input logic [13:0] r, input logic [3:0] deg);
      logic        fb;
      logic [14:0] mask;
      logic [13:0] m;
      unique case (deg)
         DEG_11:  fb = r[0] ^ r[3];
         DEG_12:  fb = r[0] ^ r[2];
         DEG_13:  fb = r[0] ^ r[1] ^ r[4] ^ r[6];
         DEG_14:  fb = r[0] ^ r[1] ^ r[4] ^ r[5] ^ r[9] ^ r[11];
         default: fb = r[0] ^ r[1] ^ r[2] ^ r[12];
      endcase
      mask = (15'd1 << (deg - 4'd1)) - 15'd1;
      m    = r & mask[13:0];
      return (m >> 1) | (14'(fb) << (deg - 4'd2));
   endfunction

   // counter bit-reversed over deg bits, then doubled
   function automatic logic [15:0] rev_doubled(input logic [19:0] v, input logic [3:0] deg);
      logic [14:0] r;
      for (int k = 0; k < 15; k++) begin
         r[k] = v[14-k];
      end
      return {r >> (DEG_15 - deg), 1'b0};
   endfunction

endpackage

// ===== sv/cdag_datapath.sv =====
// datapath of the cell deinterleave address generator: config, lfsr, shift, modulo, output
// depends on cdag_pkg and the assertion macro header
`include "cell_deinterleave_address_gen_unit_defines.svh"

module cdag_datapath #(
   parameter int MAX_CELLS  = cdag_pkg::MAX_CELLS_DEF,
   parameter int MAX_BLOCKS = cdag_pkg::MAX_BLOCKS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [15:0]             csr_data,
   input  cdag_pkg::cdag_cmd_type  cmd,
   output cdag_pkg::cdag_stat_type stat,
   output logic [39:0]             rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tuser
);
   import cdag_pkg::*;

   localparam logic [15:0] CELLS_CEIL  = 16'(MAX_CELLS);
   localparam logic [9:0]  BLOCKS_CEIL = 10'(MAX_BLOCKS);

   function automatic logic [15:0] clamp_cells(input logic [15:0] c);
      logic [15:0] r;
      r = c;
      if (r < CELLS_FLOOR) r = CELLS_FLOOR;
      if (r > CELLS_CEIL) r = CELLS_CEIL;
      return r;
   endfunction

   function automatic logic [9:0] clamp_blocks(input logic [9:0] b);
      logic [9:0] r;
      r = b;
      if (r < BLOCKS_FLOOR) r = BLOCKS_FLOOR;
      if (r > BLOCKS_CEIL) r = BLOCKS_CEIL;
      return r;
   endfunction

   // configuration, kept already clamped
   logic [15:0] cfg_cells_ff;
   logic [3:0]  cfg_deg_ff;
   logic [9:0]  cfg_blocks_ff;

   // generator state
   logic [13:0] pn_reg_ff;
   logic [15:0] pn_step_ff;
   logic [19:0] shift_cnt_ff;
   logic [14:0] block_shift_ff;
   logic [9:0]  block_cnt_ff;
   logic [14:0] cell_cnt_ff;
   logic        need_shift_ff;
   logic [15:0] sum_ff;

   // result register
   logic [9:0]  rsp_block_ff;
   logic [14:0] rsp_cell_ff;
   logic [14:0] rsp_target_ff;
   logic        rsp_lob_ff;
   logic        rsp_loa_ff;

   logic [15:0] cand_shift;
   logic [15:0] deg_span;
   logic [15:0] pn_idx;
   logic [13:0] pn_reg_in;
   logic [14:0] pn_value;
   logic        lob;
   logic        loa;

   assign csr_ready = 1'b1;

   always_comb begin
      cand_shift = rev_doubled(shift_cnt_ff, cfg_deg_ff);
      deg_span   = 16'd1 << cfg_deg_ff;
      pn_idx     = (pn_step_ff >= deg_span) ? 16'd0 : pn_step_ff;
      if (pn_idx < 16'd2) begin
         pn_reg_in = 14'd0;
      end else if (pn_idx == 16'd2) begin
         pn_reg_in = 14'd1;
      end else begin
         pn_reg_in = lfsr_next(pn_reg_ff, cfg_deg_ff);
      end
      // alternating top bit
      pn_value = 15'(pn_reg_in) | (15'(pn_idx[0]) << (cfg_deg_ff - 4'd1));
      lob = ({1'b0, cell_cnt_ff} + 16'd1) >= cfg_cells_ff;
      loa = lob && (({1'b0, block_cnt_ff} + 11'd1) >= {1'b0, cfg_blocks_ff});
   end

   assign stat.need_shift = need_shift_ff;
   assign stat.shift_ok   = cand_shift < cfg_cells_ff;
   assign stat.pn_ok      = {1'b0, pn_value} < cfg_cells_ff;
   assign stat.target_ok  = sum_ff < cfg_cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cells_ff  <= clamp_cells(CELLS_RESET);
         cfg_deg_ff    <= degree_of(clamp_cells(CELLS_RESET));
         cfg_blocks_ff <= clamp_blocks(BLOCKS_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CELLS: begin
               cfg_cells_ff <= clamp_cells(csr_data);
               cfg_deg_ff   <= degree_of(clamp_cells(csr_data));
            end
            CSR_BLOCKS: begin
               cfg_blocks_ff <= clamp_blocks(csr_data[9:0]);
            end
            default: begin
               cfg_blocks_ff <= cfg_blocks_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         pn_reg_ff      <= '0;
         pn_step_ff     <= '0;
         shift_cnt_ff   <= '0;
         block_shift_ff <= '0;
         block_cnt_ff   <= '0;
         cell_cnt_ff    <= '0;
         need_shift_ff  <= 1'b1;
      end else if (cmd.shift_adv) begin
         shift_cnt_ff <= shift_cnt_ff + 20'd1;
         if (stat.shift_ok) begin
            block_shift_ff <= cand_shift[14:0];
            need_shift_ff  <= 1'b0;
         end
      end else if (cmd.pn_adv) begin
         pn_reg_ff  <= pn_reg_in;
         pn_step_ff <= pn_idx + 16'd1;
      end else if (cmd.emit) begin
         if (lob) begin
            cell_cnt_ff   <= '0;
            pn_step_ff    <= '0;
            pn_reg_ff     <= '0;
            need_shift_ff <= 1'b1;
            if (loa) begin
               block_cnt_ff <= '0;
               shift_cnt_ff <= '0;
            end else begin
               block_cnt_ff <= block_cnt_ff + 10'd1;
            end
         end else begin
            cell_cnt_ff <= cell_cnt_ff + 15'd1;
         end
      end
   end

   // sum of pn value and block shift, then reduced below the cell count
   always_ff @(posedge clock) begin
      if (cmd.pn_adv) begin
         sum_ff <= {1'b0, pn_value} + {1'b0, block_shift_ff};
      end else if (cmd.reduce) begin
         sum_ff <= sum_ff - cfg_cells_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_block_ff  <= block_cnt_ff;
         rsp_cell_ff   <= cell_cnt_ff;
         rsp_target_ff <= sum_ff[14:0];
         rsp_lob_ff    <= lob;
         rsp_loa_ff    <= loa;
      end
   end

   assign rsp_tdata = {rsp_target_ff, rsp_cell_ff, rsp_block_ff};
   assign rsp_tlast = rsp_lob_ff;
   assign rsp_tuser = rsp_loa_ff;

   `CDAG_ASSERT_NEXT(a_restart_clears, cmd.restart,
      need_shift_ff && cell_cnt_ff == 15'd0 && block_cnt_ff == 10'd0,
      "restart did not clear the generator")
   `CDAG_ASSERT_NOW(a_target_in_range, cmd.emit, sum_ff < cfg_cells_ff,
      "target emitted before reduction finished")
   `CDAG_ASSERT_NEXT(a_block_end_rearms, cmd.emit && lob,
      need_shift_ff && cell_cnt_ff == 15'd0 && pn_step_ff == 16'd0,
      "end of block did not rearm the shift")

endmodule

// ===== sv/cdag_ctrl.sv =====
// controller of the cell deinterleave address generator: sequencing and handshakes
// depends on cdag_pkg and the assertion macro header
`include "cell_deinterleave_address_gen_unit_defines.svh"

module cdag_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_restart,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  cdag_pkg::cdag_stat_type stat,
   output cdag_pkg::cdag_cmd_type  cmd
);
   import cdag_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PN,
      ST_REDUCE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.restart   = accept && req_restart;
      cmd.shift_adv = state_ff == ST_SHIFT;
      cmd.pn_adv    = state_ff == ST_PN;
      cmd.reduce    = (state_ff == ST_REDUCE) && !stat.target_ok;
      cmd.emit      = (state_ff == ST_REDUCE) && stat.target_ok && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_restart || stat.need_shift) ? ST_SHIFT : ST_PN;
         end
         ST_SHIFT: begin
            if (stat.shift_ok) state_in = ST_PN;
         end
         ST_PN: begin
            if (stat.pn_ok) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (cmd.emit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   `CDAG_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_valid_ff,
      "emitted result not presented")
   `CDAG_ASSERT_NEXT(a_accept_starts_work, accept, state_ff != ST_IDLE,
      "accepted item did not start work")
   `CDAG_ASSERT_NOW(a_emit_needs_room, cmd.emit, !rsp_valid_ff || rsp_tready,
      "result register overwritten while held")

endmodule

// ===== sv/cell_deinterleave_address_gen_unit.sv =====
// cell deinterleave address generator: every request item yields one address pair
// a result channel carries block, cell and target position; restart rides in req_tdata
// sequence: after the accepting edge the sequencer takes an lfsr step, then a range check
// that loads the output register; each lfsr value at or above the cell count costs
// another lfsr step, each extra subtract of the modulo repeats the range check, the first
// pair of every block first tries shift candidates, and the load waits while a result is held
// items pass idle, lfsr step and range check in turn, and a new item is taken only once
// the last is emitted, as the single shared lfsr stepper and compare/subtract unit serve
// one item at a time; req_tready is high only while the sequencer is idle
// the result waits in an output register; a stalled rsp_tready does not stop the
// next item from being accepted and worked on, only its final hand-off waits
// reset: synchronous, clears the generator to block zero, cell zero; cells_per_block
// returns to 32400 and blocks_in_use to 1; the csr port is always ready
// csr writes apply at once; write only between items
// depends on cdag_pkg, cdag_ctrl and cdag_datapath

module cell_deinterleave_address_gen_unit #(
   parameter int MAX_CELLS  = cdag_pkg::MAX_CELLS_DEF,
   parameter int MAX_BLOCKS = cdag_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [9:0] block_index, [24:10] cell_index,
                                    // [39:25] target_position
   output logic        rsp_tlast,   // last_of_block
   output logic        rsp_tuser,   // [0] last_of_all
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,   // 0 cells_per_block, 1 blocks_in_use
   input  logic [15:0] csr_data
);
   import cdag_pkg::*;

   cdag_cmd_type  cmd;
   cdag_stat_type stat;

   // sequencer: handshakes and command issue
   cdag_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // lfsr, block shift, modulo and result register
   cdag_datapath #(
      .MAX_CELLS  (MAX_CELLS),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
